// File: src/pap_pkg.sv
// Shared types and constants for the polygon area and perimeter block.
package pap_pkg;

  localparam int CROSS_W = 48;
  localparam int AREA_W  = 47;
  localparam int PERIM_W = 32;

  localparam logic [AREA_W-1:0]  AREA_MAX  = '1;
  localparam logic [PERIM_W-1:0] PERIM_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_SQRT,
    S_ACC,
    S_CLOSE,
    S_EMIT
  } pap_state_t;

endpackage

// File: src/polygon_area_perimeter.sv
// Polygon area and perimeter: bit-serial shoelace sum and edge-length accumulator.
//
// Input channel (in_*): one vertex per item, signed fixed point, with
// in_last_vertex closing the open polygon and in_last_polygon (read only with
// in_last_vertex) ending the group. Result channel (out_*): one item per group,
// the saturated area total and perimeter total, after which both totals clear.
// Each edge runs four one-bit-per-cycle multipliers (two cross terms, dx^2 and
// dy^2), then a restoring square root that retires one root bit per cycle. A
// vertex that opens a polygon runs no edge and a later vertex runs one edge; a
// closing vertex adds one more edge plus a close step, and the last vertex of
// a group adds one more step that moves the totals into the output register.
// The result sits in an output register; the next item is accepted while it
// waits. Only a second result can stall the block until the first is taken.
// Reset (rst_n low, synchronous) empties the open polygon and clears totals.
module polygon_area_perimeter
  import pap_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_x_coord,
  input  logic signed [COORD_BITS-1:0] in_y_coord,
  input  logic                         in_last_vertex,
  input  logic                         in_last_polygon,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [AREA_W-1:0]            out_area_total,
  output logic [PERIM_W-1:0]           out_perimeter_total
);

  localparam int C     = COORD_BITS;
  localparam int W     = C + 1;          // multiplier operand width
  localparam int R     = C + 1;          // root width
  localparam int SW    = 2 * R;          // radicand width
  localparam int PW    = 2 * W;          // product width
  localparam int SUMW  = ((PW > CROSS_W) ? PW : CROSS_W) + 1;
  localparam int ES_W  = ((R > PERIM_W) ? R : PERIM_W) + 1;
  localparam int CNT_W = $clog2(W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);
  localparam logic signed [SUMW-1:0] SUM_MAX = SUMW'({1'b0, {(CROSS_W-1){1'b1}}});
  localparam logic signed [SUMW-1:0] SUM_MIN = -SUM_MAX - SUMW'(1);

  function automatic logic signed [CROSS_W-1:0] clamp_cross(input logic signed [SUMW-1:0] v);
    logic signed [SUMW-1:0] t;
    t = v;
    if (v > SUM_MAX) t = SUM_MAX;
    if (v < SUM_MIN) t = SUM_MIN;
    return t[CROSS_W-1:0];
  endfunction

  pap_state_t state_r, state_nxt;

  logic signed [C-1:0]       first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic                      have_first_r, closing_r, lv_r, lp_r;
  logic signed [CROSS_W-1:0] cross_sum_r;
  logic [PERIM_W-1:0]        edge_sum_r, perim_acc_r;
  logic [AREA_W-1:0]         area_acc_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [W-1:0]       mc_r [4];
  logic signed [W:0]         hi_r [4];
  logic [W-1:0]              lo_r [4];
  logic [SW-1:0]             sq_r;
  logic [R:0]                rem_r;
  logic [R-1:0]              root_r;
  logic                      out_valid_r;
  logic [AREA_W-1:0]         out_area_r;
  logic [PERIM_W-1:0]        out_perim_r;

  logic load_edge, out_free, accept, cnt_last;

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    load_edge = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (have_first_r || in_last_vertex)) begin
          state_nxt = S_MUL;
          load_edge = 1'b1;
        end
      end
      S_MUL:  if (cnt_last) state_nxt = S_SUM;
      S_SUM:  state_nxt = S_SQRT;
      S_SQRT: if (cnt_last) state_nxt = S_ACC;
      S_ACC: begin
        if (!closing_r && lv_r) begin
          state_nxt = S_MUL;
          load_edge = 1'b1;
        end else if (lv_r) begin
          state_nxt = S_CLOSE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_CLOSE: state_nxt = lp_r ? S_EMIT : S_IDLE;
      S_EMIT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign cnt_last = (cnt_r == CNT_LAST);

  // ---------------------------------------------------------- edge operands
  // A fresh polygon's first vertex closes onto itself; otherwise the edge
  // starts at the previous vertex. The closing edge ends at the first vertex.
  logic signed [C-1:0] ax, ay, bx, by;
  logic signed [C:0]   dx_s, dy_s;
  logic signed [W-1:0] dx_m, dy_m;
  logic signed [W-1:0] mc_ld [4];
  logic signed [W-1:0] ml_ld [4];

  always_comb begin
    ax = (state_r == S_IDLE && !have_first_r) ? in_x_coord : prev_x_r;
    ay = (state_r == S_IDLE && !have_first_r) ? in_y_coord : prev_y_r;
    bx = (state_r == S_IDLE) ? in_x_coord : first_x_r;
    by = (state_r == S_IDLE) ? in_y_coord : first_y_r;
    dx_s = W'(ax) - W'(bx);
    dy_s = W'(ay) - W'(by);
    dx_m = dx_s[C] ? -dx_s : dx_s;
    dy_m = dy_s[C] ? -dy_s : dy_s;
    mc_ld[0] = W'(ax);  ml_ld[0] = W'(by);
    mc_ld[1] = W'(bx);  ml_ld[1] = W'(ay);
    mc_ld[2] = dx_m;    ml_ld[2] = dx_m;
    mc_ld[3] = dy_m;    ml_ld[3] = dy_m;
  end

  // ------------------------------------------------- serial multiplier lanes
  // Shift-add over the multiplier bits, LSB first; the sign bit weighs
  // negative on the last step.
  logic signed [W+1:0] addend [4];
  logic signed [W+1:0] psum   [4];
  logic signed [PW-1:0] prod  [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      addend[l] = '0;
      if (lo_r[l][0]) begin
        addend[l] = cnt_last ? -((W+2)'(mc_r[l])) : (W+2)'(mc_r[l]);
      end
      psum[l] = (W+2)'(hi_r[l]) + addend[l];
      prod[l] = $signed({hi_r[l][W-1:0], lo_r[l]});
    end
  end

  // ------------------------------------------------------------ square root
  logic [R+2:0] rem_sh, trial, rem_diff;
  logic         root_bit;

  always_comb begin
    rem_sh   = {rem_r, sq_r[SW-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    root_bit = (rem_sh >= trial);
    rem_diff = root_bit ? (rem_sh - trial) : rem_sh;
  end

  // ----------------------------------------------------------- accumulation
  logic signed [CROSS_W-1:0] cross_add, cross_sub;
  logic [ES_W-1:0]           es_sum;
  logic [PERIM_W-1:0]        edge_sat;
  logic [CROSS_W-1:0]        cross_mag;
  logic [AREA_W:0]           area_sum;
  logic [PERIM_W:0]          perim_sum;
  logic [AREA_W-1:0]         area_sat;
  logic [PERIM_W-1:0]        perim_sat;
  logic [SW-1:0]             sq_ld;

  always_comb begin
    cross_add = clamp_cross(SUMW'(cross_sum_r) + SUMW'(prod[0]));
    cross_sub = clamp_cross(SUMW'(cross_sum_r) - SUMW'(prod[1]));
    sq_ld     = SW'(prod[2]) + SW'(prod[3]);
    es_sum    = ES_W'(edge_sum_r) + ES_W'(root_r);
    edge_sat  = (es_sum >= ES_W'(PERIM_MAX)) ? PERIM_MAX : es_sum[PERIM_W-1:0];
    cross_mag = cross_sum_r[CROSS_W-1] ? CROSS_W'(-cross_sum_r) : CROSS_W'(cross_sum_r);
    area_sum  = {1'b0, area_acc_r} + {1'b0, cross_mag[CROSS_W-1:1]};
    area_sat  = (area_sum >= (AREA_W+1)'(AREA_MAX)) ? AREA_MAX : area_sum[AREA_W-1:0];
    perim_sum = {1'b0, perim_acc_r} + {1'b0, edge_sum_r};
    perim_sat = (perim_sum >= (PERIM_W+1)'(PERIM_MAX)) ? PERIM_MAX : perim_sum[PERIM_W-1:0];
  end

  // ------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_x_r    <= '0;
      first_y_r    <= '0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      have_first_r <= 1'b0;
      closing_r    <= 1'b0;
      lv_r         <= 1'b0;
      lp_r         <= 1'b0;
      cross_sum_r  <= '0;
      edge_sum_r   <= '0;
      area_acc_r   <= '0;
      perim_acc_r  <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        lv_r         <= in_last_vertex;
        lp_r         <= in_last_polygon;
        prev_x_r     <= in_x_coord;
        prev_y_r     <= in_y_coord;
        have_first_r <= 1'b1;
        closing_r    <= !have_first_r;
        if (!have_first_r) begin
          first_x_r <= in_x_coord;
          first_y_r <= in_y_coord;
        end
      end
      if (state_r == S_ACC && load_edge) closing_r <= 1'b1;

      if (load_edge || state_r == S_SUM) begin
        cnt_r <= '0;
      end else if ((state_r == S_MUL || state_r == S_SQRT) && !cnt_last) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end

      if (state_r == S_SUM) cross_sum_r <= cross_add;
      if (state_r == S_SQRT && cnt_r == '0) cross_sum_r <= cross_sub;
      if (state_r == S_ACC) edge_sum_r <= edge_sat;

      if (state_r == S_CLOSE) begin
        area_acc_r   <= area_sat;
        perim_acc_r  <= perim_sat;
        cross_sum_r  <= '0;
        edge_sum_r   <= '0;
        have_first_r <= 1'b0;
      end

      if (state_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
        area_acc_r  <= '0;
        perim_acc_r <= '0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      if (load_edge) begin
        mc_r[l] <= mc_ld[l];
        hi_r[l] <= '0;
        lo_r[l] <= ml_ld[l];
      end else if (state_r == S_MUL) begin
        hi_r[l] <= psum[l][W+1:1];
        lo_r[l] <= {psum[l][0], lo_r[l][W-1:1]};
      end
    end
    if (state_r == S_SUM) begin
      sq_r   <= sq_ld;
      rem_r  <= '0;
      root_r <= '0;
    end else if (state_r == S_SQRT) begin
      sq_r   <= {sq_r[SW-3:0], 2'b00};
      rem_r  <= rem_diff[R:0];
      root_r <= {root_r[R-2:0], root_bit};
    end
    if (state_r == S_EMIT && out_free) begin
      out_area_r  <= area_acc_r;
      out_perim_r <= perim_acc_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_area_total      = out_area_r;
  assign out_perimeter_total = out_perim_r;

  // ------------------------------------------------------------ assertions
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_LAST)
    else $error("step counter out of range");

  a_empty_polygon: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !have_first_r) |-> (cross_sum_r == '0 && edge_sum_r == '0))
    else $error("open-polygon sums not clear without a vertex");

  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLOSE) |=> (!have_first_r && cross_sum_r == '0))
    else $error("polygon state not cleared on close");

  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_free) |=>
      (out_valid_r && area_acc_r == '0 && perim_acc_r == '0))
    else $error("group totals not moved to output");

endmodule

// File: test/polygon_area_perimeter_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the polygon area and perimeter block.
module polygon_area_perimeter_test
  import pap_pkg::*;
();

  typedef longint unsigned u64_t;

  localparam int COORD_BITS    = 16;
  localparam int HOLD_CYCLES   = 1500;
  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 200;

  localparam longint CROSS_HI = (longint'(1) << (CROSS_W - 1)) - 1;
  localparam longint CROSS_LO = -CROSS_HI - 1;
  localparam u64_t   AREA_CAP  = u64_t'(AREA_MAX);
  localparam u64_t   PERIM_CAP = u64_t'(PERIM_MAX);

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    bit                           last_vertex;
    bit                           last_polygon;
    bit                           drain_first;
  } vertex_t;

  typedef struct {
    logic [AREA_W-1:0]  area;
    logic [PERIM_W-1:0] perim;
  } totals_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic signed [COORD_BITS-1:0] in_x_coord = '0;
  logic signed [COORD_BITS-1:0] in_y_coord = '0;
  logic                         in_last_vertex = 1'b0;
  logic                         in_last_polygon = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [AREA_W-1:0]            out_area_total;
  logic [PERIM_W-1:0]           out_perimeter_total;

  vertex_t vtx_q[$];
  totals_t totals_due[$];
  vertex_t cur_vtx;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  bit hold_req     = 1'b0;
  bit hold_taken   = 1'b0;
  int hold_left    = 0;
  int quiet_cycles = 0;
  int mismatches   = 0;

  // running state of the open polygon and the group totals
  longint          poly_first_x = 0, poly_first_y = 0;
  longint          poly_prev_x = 0, poly_prev_y = 0;
  bit              poly_open = 1'b0;
  longint          cross_acc = 0;
  longint unsigned edge_acc = 0, area_acc = 0, perim_acc = 0;

  polygon_area_perimeter DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_x_coord          (in_x_coord),
    .in_y_coord          (in_y_coord),
    .in_last_vertex      (in_last_vertex),
    .in_last_polygon     (in_last_polygon),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_area_total      (out_area_total),
    .out_perimeter_total (out_perimeter_total)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r;
    longint unsigned trial;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = r | (u64_t'(1) << b);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b,
                                              longint unsigned cap);
    longint unsigned s;
    s = a + b;
    return (s >= cap) ? cap : s;
  endfunction

  function automatic longint clamp_cross(longint v);
    if (v > CROSS_HI) return CROSS_HI;
    if (v < CROSS_LO) return CROSS_LO;
    return v;
  endfunction

  task automatic add_edge_terms(longint ax, longint ay, longint bx, longint by);
    longint unsigned dx;
    longint unsigned dy;
    dx = (ax >= bx) ? u64_t'(ax - bx) : u64_t'(bx - ax);
    dy = (ay >= by) ? u64_t'(ay - by) : u64_t'(by - ay);
    edge_acc  = sat_add(edge_acc, floor_root(dx * dx + dy * dy), PERIM_CAP);
    // each cross product is clamped on its own
    cross_acc = clamp_cross(cross_acc + ax * by);
    cross_acc = clamp_cross(cross_acc - bx * ay);
  endtask

  task automatic shoelace_step(vertex_t v);
    longint          x;
    longint          y;
    longint unsigned mag;
    totals_t         t;
    x = v.x;
    y = v.y;
    if (!poly_open) begin
      poly_first_x = x;
      poly_first_y = y;
      poly_open    = 1'b1;
    end else begin
      add_edge_terms(poly_prev_x, poly_prev_y, x, y);
    end
    poly_prev_x = x;
    poly_prev_y = y;
    if (v.last_vertex) begin
      add_edge_terms(poly_prev_x, poly_prev_y, poly_first_x, poly_first_y);
      mag       = (cross_acc < 0) ? u64_t'(-cross_acc)
                                  : u64_t'(cross_acc);
      area_acc  = sat_add(area_acc, mag >> 1, AREA_CAP);
      perim_acc = sat_add(perim_acc, edge_acc, PERIM_CAP);
      cross_acc = 0;
      edge_acc  = 0;
      poly_open = 1'b0;
      if (v.last_polygon) begin
        t.area  = area_acc[AREA_W-1:0];
        t.perim = perim_acc[PERIM_W-1:0];
        totals_due.push_back(t);
        area_acc  = 0;
        perim_acc = 0;
      end
    end
  endtask

  // sender
  always @(posedge clk) begin : drive_vertices
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) shoelace_step(cur_vtx);
      // a drain marker holds the item until no result is outstanding
      if (vtx_q.size() != 0 && $urandom_range(99) >= tx_idle_pct &&
          !(vtx_q[0].drain_first && (out_valid || totals_due.size() != 0))) begin
        cur_vtx = vtx_q.pop_front();
        in_x_coord      <= cur_vtx.x;
        in_y_coord      <= cur_vtx.y;
        in_last_vertex  <= cur_vtx.last_vertex;
        in_last_polygon <= cur_vtx.last_polygon;
        in_valid        <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin : drive_ready
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin : check_totals
    totals_t t;
    if (rst_n && out_valid && out_ready) begin
      if (totals_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: area %0d, perimeter %0d",
                   out_area_total, out_perimeter_total);
      end else begin
        t = totals_due.pop_front();
        if (out_area_total !== t.area) begin
          mismatches++;
          if (mismatches <= 10)
            $display("area mismatch: expected %0d, got %0d", t.area, out_area_total);
        end
        if (out_perimeter_total !== t.perim) begin
          mismatches++;
          if (mismatches <= 10)
            $display("perimeter mismatch: expected %0d, got %0d",
                     t.perim, out_perimeter_total);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("no progress for %0d cycles", STALL_LIMIT);
      $display("** polygon_area_perimeter: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_vertex(int x, int y, bit lv, bit lp);
    vertex_t v;
    v.x            = COORD_BITS'(x);
    v.y            = COORD_BITS'(y);
    v.last_vertex  = lv;
    v.last_polygon = lp;
    v.drain_first  = 1'b0;
    vtx_q.push_back(v);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(3))
      0: return int'($urandom_range(65535)) - 32768;
      1: return int'($urandom_range(128)) - 64;
      2: begin
        case ($urandom_range(3))
          0: return -32768;
          1: return 32767;
          2: return -1;
          default: return 0;
        endcase
      end
      default: return int'($urandom_range(8192)) - 4096;
    endcase
  endfunction

  // one group: a few polygons, the last one flagged as the group end
  task automatic push_group(bit short_only);
    int  npoly;
    int  nv;
    bit  lv;
    npoly = short_only ? 1 : $urandom_range(3, 1);
    for (int p = 0; p < npoly; p++) begin
      if (short_only || $urandom_range(9) == 0) nv = $urandom_range(2, 1);
      else nv = $urandom_range(7, 3);
      for (int i = 0; i < nv; i++) begin
        lv = (i == nv - 1);
        // stray group-end flags on open vertices must be ignored
        add_vertex(rand_coord(), rand_coord(), lv,
                   lv ? (p == npoly - 1) : ($urandom_range(7) == 0));
      end
    end
  endtask

  task automatic wait_sent();
    while (vtx_q.size() != 0) @(negedge clk);
  endtask

  task automatic random_phase(int n, int tx_pct, int rx_pct, bit short_only);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    while (vtx_q.size() < n) push_group(short_only);
    vtx_q[0].drain_first = 1'b1;
    wait_sent();
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // one-vertex polygon: zero area, zero perimeter
    add_vertex(-32768, 32767, 1'b1, 1'b1);
    // two vertices at opposite corners, group flag early on an open vertex
    add_vertex(-32768, -32768, 1'b0, 1'b1);
    add_vertex(32767, 32767, 1'b1, 1'b1);
    // chained group: large triangle, clockwise full-range square, odd sums
    add_vertex(0, 0, 1'b0, 1'b0);
    add_vertex(32767, 0, 1'b0, 1'b0);
    add_vertex(0, 32767, 1'b1, 1'b0);
    add_vertex(-32768, -32768, 1'b0, 1'b0);
    add_vertex(-32768, 32767, 1'b0, 1'b0);
    add_vertex(32767, 32767, 1'b0, 1'b0);
    add_vertex(32767, -32768, 1'b1, 1'b0);
    add_vertex(0, 0, 1'b0, 1'b0);
    add_vertex(1, 0, 1'b0, 1'b0);
    add_vertex(0, 1, 1'b1, 1'b0);
    add_vertex(0, 0, 1'b0, 1'b0);
    add_vertex(0, 1, 1'b0, 1'b0);
    add_vertex(1, 0, 1'b1, 1'b1);
    // alternating bit patterns
    add_vertex('h5555, -21846, 1'b0, 1'b0);
    add_vertex(-21846, 'h5555, 1'b1, 1'b1);
    wait_sent();

    random_phase(130, 0, 0, 1'b0);
    random_phase(130, 56, 0, 1'b0);
    random_phase(130, 0, 56, 1'b0);
    random_phase(130, 34, 34, 1'b0);

    // drain first, so that the hold below stalls the block and not the sender
    while (in_valid || out_valid || totals_due.size() != 0) @(negedge clk);

    // receiver holds off while short groups keep coming
    hold_req = 1'b1;
    random_phase(60, 0, 0, 1'b1);

    random_phase(100, 34, 34, 1'b0);

    while (vtx_q.size() != 0 || in_valid || out_valid || totals_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatches == 0 && totals_due.size() == 0) begin
      $display("** polygon_area_perimeter: PASSED **");
    end else begin
      $display("** polygon_area_perimeter: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
src/pap_pkg.sv
src/polygon_area_perimeter.sv
test/polygon_area_perimeter_test.sv
